### rtl/bole_pkg.sv
`default_nettype none
package bole_pkg;
  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 32;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_PUSH   = 3'd1,
    REQ_POP    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_FIRST  = 3'd4,
    REQ_NEXT   = 3'd5,
    REQ_LAST   = 3'd6,
    REQ_BAD    = 3'd7
  } req_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] item_out;
    logic        status;
    logic [4:0]  entry_count;
    logic [31:0] head_item;
    logic [31:0] tail_item;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take request into datapath registers
    logic exec;   // apply request to the list
  } dp_cmd_t;
endpackage
`default_nettype wire

### rtl/bole_ctrl.sv
`default_nettype none
module bole_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bole_pkg::dp_cmd_t  cmd
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.exec  = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/bole_dp.sv
`default_nettype none
module bole_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bole_pkg::dp_cmd_t  cmd,
  input  wire bole_pkg::in_item_t in_data,
  output bole_pkg::out_item_t     out_data
);
  localparam int CAPACITY  = bole_pkg::CAPACITY;
  localparam int ITEM_BITS = bole_pkg::ITEM_BITS;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ITEM_BITS-1:0] ent_r [CAPACITY];
  logic [CW-1:0]        cnt_r;
  logic [IW-1:0]        cur_r;
  logic                 cur_v_r;
  logic [2:0]           req_r;
  logic [ITEM_BITS-1:0] val_r;
  logic [ITEM_BITS-1:0] found_r;
  logic                 rej_r;

  // first-match search, per-cell
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] prior_hit;
  logic [IW-1:0]       hit_idx;
  logic                any_hit;
  logic                full;

  always_comb begin
    hit_idx = '0;
    any_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (CW'(i) < cnt_r) && (ent_r[i] == val_r);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IW'(i);
        any_hit = 1'b1;
      end
    end
    prior_hit[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) prior_hit[i] = prior_hit[i-1] | hit[i-1];
  end

  assign full = (cnt_r == CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data.req_type;
      val_r <= in_data.item_value[ITEM_BITS-1:0];
    end
    if (cmd.exec) begin
      found_r <= '0;
      rej_r   <= 1'b0;
      unique case (bole_pkg::req_t'(req_r))
        bole_pkg::REQ_APPEND: begin
          if (val_r == '0 || full) rej_r <= 1'b1;
          else ent_r[cnt_r[IW-1:0]] <= val_r;
        end
        bole_pkg::REQ_PUSH: begin
          if (full) rej_r <= 1'b1;
          else begin
            for (int i = 1; i < CAPACITY; i++) ent_r[i] <= ent_r[i-1];
            ent_r[0] <= val_r;
          end
        end
        bole_pkg::REQ_POP: begin
          if (cnt_r != '0) begin
            found_r <= ent_r[0];
            for (int i = 0; i < CAPACITY - 1; i++) ent_r[i] <= ent_r[i+1];
          end
        end
        bole_pkg::REQ_REMOVE: begin
          for (int i = 0; i < CAPACITY - 1; i++)
            if (prior_hit[i] | hit[i]) ent_r[i] <= ent_r[i+1];
        end
        bole_pkg::REQ_FIRST: if (cnt_r != '0) found_r <= ent_r[0];
        bole_pkg::REQ_NEXT: begin
          if (!cur_v_r) begin
            if (cnt_r != '0) found_r <= ent_r[0];
          end else if (CW'(cur_r) + CW'(1) < cnt_r) begin
            found_r <= ent_r[cur_r + IW'(1)];
          end
        end
        bole_pkg::REQ_LAST: if (cnt_r != '0) found_r <= ent_r[cnt_r[IW-1:0] - IW'(1)];
        default: rej_r <= 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      cur_r   <= '0;
      cur_v_r <= 1'b0;
    end else if (cmd.exec) begin
      unique case (bole_pkg::req_t'(req_r))
        bole_pkg::REQ_APPEND: if (!(val_r == '0 || full)) begin
          cnt_r <= cnt_r + CW'(1); cur_r <= '0; cur_v_r <= 1'b0;
        end
        bole_pkg::REQ_PUSH: if (!full) begin
          cnt_r <= cnt_r + CW'(1); cur_r <= '0; cur_v_r <= 1'b0;
        end
        bole_pkg::REQ_POP: begin
          if (cnt_r != '0) cnt_r <= cnt_r - CW'(1);
          cur_r <= '0; cur_v_r <= 1'b0;
        end
        bole_pkg::REQ_REMOVE: if (any_hit) begin
          cnt_r <= cnt_r - CW'(1);
          if (cur_v_r) begin
            if (cur_r == hit_idx) begin
              if (hit_idx == '0) begin
                cur_v_r <= 1'b0; cur_r <= '0;
              end else cur_r <= cur_r - IW'(1);
            end else if (cur_r > hit_idx) cur_r <= cur_r - IW'(1);
          end
        end
        bole_pkg::REQ_FIRST: begin
          cur_r <= '0; cur_v_r <= (cnt_r != '0);
        end
        bole_pkg::REQ_NEXT: begin
          if (!cur_v_r) begin
            cur_r <= '0; cur_v_r <= (cnt_r != '0);
          end else if (CW'(cur_r) + CW'(1) < cnt_r) begin
            cur_r <= cur_r + IW'(1);
          end else begin
            cur_r <= '0; cur_v_r <= 1'b0;
          end
        end
        bole_pkg::REQ_LAST: begin
          if (cnt_r != '0) begin
            cur_r <= cnt_r[IW-1:0] - IW'(1); cur_v_r <= 1'b1;
          end else begin
            cur_r <= '0; cur_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data             = '0;
    out_data.item_out    = 32'(found_r);
    out_data.status      = rej_r;
    out_data.entry_count = 5'(cnt_r);
    if (cnt_r != '0) begin
      out_data.head_item = 32'(ent_r[0]);
      out_data.tail_item = 32'(ent_r[cnt_r[IW-1:0] - IW'(1)]);
    end
  end
endmodule
`default_nettype wire

### rtl/bounded_ordered_list_engine_unit.sv
`default_nettype none
// channel | ports                          | transfer when
// in      | in_valid, in_ready, in_data    | in_valid && in_ready
// out     | out_valid, out_ready, out_data | out_valid && out_ready
// Each request is loaded, then executed in one step in which every list cell
// compares and shifts together; the result is held until transferred.
// A new request is taken in the same cycle the result transfers.
// Synchronous active-low reset empties the list and clears the cursor.
module bounded_ordered_list_engine_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bole_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bole_pkg::out_item_t      out_data
);
  bole_pkg::dp_cmd_t cmd;

  bole_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  bole_dp u_dp (
    .clk, .rst_n, .cmd, .in_data, .out_data
  );
endmodule
`default_nettype wire

### verif/bole_list_checker.sv
module bole_list_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bole_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bole_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  logic [31:0]         list_q [DEPTH];
  int unsigned         list_len;
  int unsigned         cur_pos;
  bit                  cur_on;
  bole_pkg::out_item_t awaited_q [$];

  function automatic void seek(input int unsigned pos, output logic [31:0] got);
    if (pos < list_len) begin
      cur_on  = 1'b1;
      cur_pos = pos;
      got     = list_q[pos];
    end else begin
      cur_on  = 1'b0;
      cur_pos = 0;
      got     = '0;
    end
  endfunction

  function automatic void drop(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < list_len; k++) list_q[k] = list_q[k + 1];
    list_len--;
  endfunction

  function automatic bole_pkg::out_item_t apply_request(input bole_pkg::in_item_t rq);
    bole_pkg::out_item_t r;
    logic [31:0]         got;
    int unsigned         k;
    got = '0;
    r   = '0;
    case (bole_pkg::req_t'(rq.req_type))
      bole_pkg::REQ_APPEND: begin
        if (rq.item_value == 0 || list_len >= DEPTH) r.status = 1'b1;
        else begin
          list_q[list_len] = rq.item_value;
          list_len++;
          cur_on = 1'b0; cur_pos = 0;
        end
      end
      bole_pkg::REQ_PUSH: begin
        if (list_len >= DEPTH) r.status = 1'b1;
        else begin
          for (k = list_len; k > 0; k--) list_q[k] = list_q[k - 1];
          list_q[0] = rq.item_value;
          list_len++;
          cur_on = 1'b0; cur_pos = 0;
        end
      end
      bole_pkg::REQ_POP: begin
        if (list_len > 0) begin
          got = list_q[0];
          drop(0);
        end
        cur_on = 1'b0; cur_pos = 0;
      end
      bole_pkg::REQ_REMOVE: begin
        for (k = 0; k < list_len; k++) if (list_q[k] == rq.item_value) break;
        if (k < list_len) begin
          drop(k);
          if (cur_on) begin
            if (cur_pos == k) begin
              if (k == 0) begin
                cur_on = 1'b0; cur_pos = 0;
              end else cur_pos = k - 1;
            end else if (cur_pos > k) cur_pos--;
          end
        end
      end
      bole_pkg::REQ_FIRST: seek(0, got);
      bole_pkg::REQ_NEXT:  seek(cur_on ? cur_pos + 1 : 0, got);
      bole_pkg::REQ_LAST:  seek(list_len > 0 ? list_len - 1 : DEPTH, got);
      default:             r.status = 1'b1;
    endcase
    r.item_out    = got;
    r.entry_count = list_len[4:0];
    r.head_item   = list_len > 0 ? list_q[0] : '0;
    r.tail_item   = list_len > 0 ? list_q[list_len - 1] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    bole_pkg::out_item_t want;
    if (!rst_n) begin
      list_len = 0; cur_pos = 0; cur_on = 1'b0;
      awaited_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
      pending      <= 0;
    end else begin
      if (in_valid && in_ready) awaited_q.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want.item_out !== out_data.item_out || want.status !== out_data.status ||
              want.entry_count !== out_data.entry_count ||
              want.head_item !== out_data.head_item ||
              want.tail_item !== out_data.tail_item) begin
            if (fail_count < 10)
              $display("mismatch: expected %p got %p", want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= awaited_q.size();
    end
  end
endmodule

### verif/bounded_ordered_list_engine_unit_tb.sv
module bounded_ordered_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 5000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                out_ready = 1'b0;
  bole_pkg::in_item_t  in_data = '0;
  logic                in_ready;
  logic                out_valid;
  bole_pkg::out_item_t out_data;
  int                  fail_count, pending, results_seen;
  int                  send_idle_pct = 27, recv_idle_pct = 73;
  int                  quiet_cycles = 0;
  int                  sent = 0;
  logic [31:0]         pool [8];
  int                  pool_len = 0;

  always #5 clk = ~clk;

  bounded_ordered_list_engine_unit DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  bole_list_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .fail_count, .pending, .results_seen
  );

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid is dropped only when the sender idles, so back-to-back transfers
  // keep in_valid high between them
  task automatic send(input bole_pkg::req_t op, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: op, item_value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // values drawn from a small pool so removes and duplicates hit often
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 6 && pool_len > 0) return pool[$urandom_range(pool_len - 1)];
    if (r == 6) return 32'd0;
    if (r == 7) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_item();
    logic [31:0] v;
    int r;
    v = pick_value();
    if (v != 0 && pool_len < 8) begin
      pool[pool_len] = v; pool_len++;
    end else if (v != 0 && $urandom_range(3) == 0) pool[$urandom_range(7)] = v;
    r = $urandom_range(99);
    if (r < 22) send(bole_pkg::REQ_APPEND, v);
    else if (r < 36) send(bole_pkg::REQ_PUSH, v);
    else if (r < 50) send(bole_pkg::REQ_POP, v);
    else if (r < 64) send(bole_pkg::REQ_REMOVE, v);
    else if (r < 70) send(bole_pkg::REQ_FIRST, v);
    else if (r < 88) send(bole_pkg::REQ_NEXT, v);
    else if (r < 96) send(bole_pkg::REQ_LAST, v);
    else send(bole_pkg::REQ_BAD, v);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty list, fill past capacity, cursor walk, removes
    send(bole_pkg::REQ_POP, 32'd0);
    send(bole_pkg::REQ_NEXT, 32'd0);
    send(bole_pkg::REQ_LAST, 32'd0);
    send(bole_pkg::REQ_APPEND, 32'd0);
    send(bole_pkg::REQ_PUSH, 32'd0);
    for (int i = 1; i <= 16; i++) send(bole_pkg::REQ_APPEND, i == 16 ? 32'hFFFF_FFFF : i);
    send(bole_pkg::REQ_PUSH, 32'h8000_0000);
    send(bole_pkg::REQ_FIRST, 32'd0);
    send(bole_pkg::REQ_NEXT, 32'd0);
    send(bole_pkg::REQ_REMOVE, 32'd0);
    send(bole_pkg::REQ_REMOVE, 32'd1);
    send(bole_pkg::REQ_LAST, 32'd0);
    send(bole_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    send(bole_pkg::REQ_NEXT, 32'd0);
    send(bole_pkg::REQ_REMOVE, 32'h1234_5678);
    send(bole_pkg::REQ_BAD, 32'h5555_AAAA);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 73; recv_idle_pct = 27;
      end else if (phase == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 380; n++) random_item();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d results over three stall mixes", sent,
             results_seen);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
